/* sv/srw_pkg.sv */
package srw_pkg;

	localparam int WindowDefault = 32;
	localparam int MaxResults    = 32;
	localparam int SeqW          = 32;
	localparam int SizeW         = 11;
	localparam int HandleW       = 16;
	localparam int DescW         = SizeW + HandleW;
	localparam logic [SizeW-1:0] FullSizeReset = 11'd1464;

	typedef struct packed {
		logic               is_tick;
		logic [SeqW-1:0]    seq_number;
		logic [SizeW-1:0]   payload_size;
		logic [HandleW-1:0] payload_handle;
	} cmd_t;

endpackage

/* sv/srw_ram.sv */
module srw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* sv/srw_front.sv */
module srw_front
	import srw_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               op,
	input  logic               is_data,
	input  logic [SeqW-1:0]    seq_number,
	input  logic [SizeW-1:0]   payload_size,
	input  logic [HandleW-1:0] payload_handle,
	output logic               q_valid,
	output cmd_t               q_item,
	input  logic               q_pop
);

	cmd_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;

	assign in_stall = (cnt_q == 2'd2);
	// drop non-data packets here; ticks and data go on to the back end
	assign push     = in_valid && !in_stall && (op || is_data);
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= '{is_tick: op, seq_number: seq_number,
				payload_size: payload_size, payload_handle: payload_handle};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, q_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* sv/srw_back.sv */
module srw_back
	import srw_pkg::*;
#(
	parameter int WINDOW = WindowDefault
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [SizeW-1:0]   cfg_wdata,
	input  logic               q_valid,
	input  cmd_t               q_item,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [SeqW-1:0]    ack_number,
	output logic               is_delivery,
	output logic [SizeW-1:0]   out_payload_size,
	output logic [HandleW-1:0] out_payload_handle,
	output logic               last_of_run,
	output logic               transfer_done
);

	localparam int IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CW = $clog2(MaxResults);
	localparam logic [1:0] StIdle = 2'd0;
	localparam logic [1:0] StRead = 2'd1;
	localparam logic [1:0] StEmit = 2'd2;
	localparam logic [IW:0]     WinW   = (IW + 1)'(WINDOW);
	localparam logic [IW-1:0]   LastSl = IW'(WINDOW - 1);

	logic [SizeW-1:0]  full_size_q;
	logic [1:0]        state_q;
	logic [SeqW-1:0]   expected_q;
	logic [IW-1:0]     head_q;
	logic [WINDOW-1:0] filled_q;
	logic              finished_q;
	logic [CW-1:0]     cnt_q;

	logic              out_valid_q;
	logic [SeqW-1:0]   ack_q;
	logic              deliv_q;
	logic [SizeW-1:0]  size_q;
	logic [HandleW-1:0] handle_q;
	logic              last_q;
	logic              done_q;

	logic              out_free;
	logic [SeqW-1:0]   offset;
	logic              in_win;
	logic [IW:0]       slot_sum;
	logic [IW-1:0]     slot;
	logic              store;
	logic              tick_emit;
	logic [DescW-1:0]  rdata;
	logic [SizeW-1:0]  rd_size;
	logic [HandleW-1:0] rd_handle;
	logic              emit;
	logic              done;
	logic [IW-1:0]     head_nxt;
	logic              nxt_filled;
	logic              last;

	assign out_free  = !out_valid_q || !out_stall;
	assign offset    = q_item.seq_number - expected_q;
	assign in_win    = offset < SeqW'(WINDOW);
	assign slot_sum  = {1'b0, head_q} + {1'b0, offset[IW-1:0]};
	assign slot      = (slot_sum >= WinW) ? IW'(slot_sum - WinW) : slot_sum[IW-1:0];
	assign q_pop     = (state_q == StIdle) && q_valid && (!q_item.is_tick || out_free);
	assign store     = q_pop && !q_item.is_tick && !finished_q && in_win;
	assign tick_emit = q_pop && q_item.is_tick && (expected_q != '0);

	assign rd_size    = rdata[DescW-1:HandleW];
	assign rd_handle  = rdata[HandleW-1:0];
	assign emit       = (state_q == StEmit) && out_free;
	assign done       = rd_size < full_size_q;
	assign head_nxt   = (head_q == LastSl) ? '0 : head_q + IW'(1);
	assign nxt_filled = filled_q[head_nxt] && (head_nxt != head_q);
	assign last       = done || (cnt_q == CW'(MaxResults - 1)) || !nxt_filled;

	srw_ram #(
		.WIDTH(DescW),
		.DEPTH(WINDOW)
	) u_desc_ram (
		.clk  (clk),
		.we   (store),
		.waddr(slot),
		.wdata({q_item.payload_size, q_item.payload_handle}),
		.raddr(head_q),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_size_q <= FullSizeReset;
			state_q     <= StIdle;
			expected_q  <= '0;
			head_q      <= '0;
			filled_q    <= '0;
			finished_q  <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				full_size_q <= cfg_wdata;
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				StIdle: begin
					cnt_q <= '0;
					if (tick_emit) begin
						out_valid_q <= 1'b1;
					end
					if (store) begin
						filled_q[slot] <= 1'b1;
						state_q        <= StRead;
					end
				end
				StRead: begin
					// descriptor at the head shows up on the RAM output next cycle
					state_q <= filled_q[head_q] ? StEmit : StIdle;
				end
				StEmit: begin
					if (emit) begin
						out_valid_q      <= 1'b1;
						filled_q[head_q] <= 1'b0;
						expected_q       <= expected_q + SeqW'(1);
						head_q           <= head_nxt;
						cnt_q            <= cnt_q + CW'(1);
						if (done) begin
							finished_q <= 1'b1;
						end
						state_q <= last ? StIdle : StRead;
					end
				end
				default: state_q <= StIdle;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (tick_emit) begin
			ack_q    <= expected_q - SeqW'(1);
			deliv_q  <= 1'b0;
			size_q   <= '0;
			handle_q <= '0;
			last_q   <= 1'b1;
			done_q   <= 1'b0;
		end else if (emit) begin
			ack_q    <= expected_q;
			deliv_q  <= 1'b1;
			size_q   <= rd_size;
			handle_q <= rd_handle;
			last_q   <= last;
			done_q   <= done;
		end
	end

	assign out_valid          = out_valid_q;
	assign ack_number         = ack_q;
	assign is_delivery        = deliv_q;
	assign out_payload_size   = size_q;
	assign out_payload_handle = handle_q;
	assign last_of_run        = last_q;
	assign transfer_done      = done_q;

endmodule

/* sv/selective_repeat_reorder_window.sv */
// Selective-repeat receive window. Packet descriptors and ack ticks enter a
// two-entry queue; non-data packets are dropped there. The back end takes a
// tick and sends its cumulative ack, unless nothing has been delivered yet. A
// data descriptor that lands in the window before the transfer ends is stored,
// and then every in-order slot drained from the head takes a descriptor RAM
// read, then the delivery into the output register, at most 32 deliveries per
// descriptor. The back end takes no new item until the deliveries that a
// stored descriptor releases are done, and output stalls hold the drain. The
// input stalls only when the queue is full. The full payload size register
// should be written only while the block is idle.
module selective_repeat_reorder_window
	import srw_pkg::*;
#(
	parameter int WINDOW = WindowDefault
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [SizeW-1:0]   cfg_wdata,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               op,
	input  logic               is_data,
	input  logic [SeqW-1:0]    seq_number,
	input  logic [SizeW-1:0]   payload_size,
	input  logic [HandleW-1:0] payload_handle,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [SeqW-1:0]    ack_number,
	output logic               is_delivery,
	output logic [SizeW-1:0]   out_payload_size,
	output logic [HandleW-1:0] out_payload_handle,
	output logic               last_of_run,
	output logic               transfer_done
);

	logic q_valid;
	cmd_t q_item;
	logic q_pop;

	srw_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.op            (op),
		.is_data       (is_data),
		.seq_number    (seq_number),
		.payload_size  (payload_size),
		.payload_handle(payload_handle),
		.q_valid       (q_valid),
		.q_item        (q_item),
		.q_pop         (q_pop)
	);

	srw_back #(
		.WINDOW(WINDOW)
	) u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_wdata         (cfg_wdata),
		.q_valid           (q_valid),
		.q_item            (q_item),
		.q_pop             (q_pop),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.ack_number        (ack_number),
		.is_delivery       (is_delivery),
		.out_payload_size  (out_payload_size),
		.out_payload_handle(out_payload_handle),
		.last_of_run       (last_of_run),
		.transfer_done     (transfer_done)
	);

endmodule

/* test/testbench.sv */
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import srw_pkg::*;

	localparam int SlotW = $clog2(WindowDefault);

	typedef struct {
		logic               op;
		logic               is_data;
		logic [SeqW-1:0]    seq;
		logic [SizeW-1:0]   size;
		logic [HandleW-1:0] handle;
	} pkt_desc_t;

	typedef struct {
		logic [SeqW-1:0]    ack;
		logic               delivery;
		logic [SizeW-1:0]   size;
		logic [HandleW-1:0] handle;
		logic               last;
		logic               done;
	} ack_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [SizeW-1:0]   cfg_wdata = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               op = 1'b0;
	logic               is_data = 1'b0;
	logic [SeqW-1:0]    seq_number = '0;
	logic [SizeW-1:0]   payload_size = '0;
	logic [HandleW-1:0] payload_handle = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [SeqW-1:0]    ack_number;
	logic               is_delivery;
	logic [SizeW-1:0]   out_payload_size;
	logic [HandleW-1:0] out_payload_handle;
	logic               last_of_run;
	logic               transfer_done;

	selective_repeat_reorder_window dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_we             (cfg_we),
		.cfg_wdata          (cfg_wdata),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.op                 (op),
		.is_data            (is_data),
		.seq_number         (seq_number),
		.payload_size       (payload_size),
		.payload_handle     (payload_handle),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.ack_number         (ack_number),
		.is_delivery        (is_delivery),
		.out_payload_size   (out_payload_size),
		.out_payload_handle (out_payload_handle),
		.last_of_run        (last_of_run),
		.transfer_done      (transfer_done)
	);

	// window state as the block should hold it
	logic [SeqW-1:0]    next_seq = '0;
	logic [SlotW-1:0]   head_slot = '0;
	bit                 slot_busy [WindowDefault];
	logic [SizeW-1:0]   slot_size [WindowDefault];
	logic [HandleW-1:0] slot_handle [WindowDefault];
	bit                 transfer_over = 1'b0;
	logic [SizeW-1:0]   full_size = FullSizeReset;

	pkt_desc_t packet_queue [$];
	ack_t      awaited_acks [$];
	bit      failed = 1'b0;
	bit      calm = 1'b0;
	int      gap_left = 0;
	int      stall_left = 0;
	int      stim_count = 0;
	logic [SeqW-1:0] gen_next = '0;

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("status: fail");
		$finish;
	end

	task automatic take_item(input logic t_op, input logic t_data, input logic [SeqW-1:0] t_seq,
			input logic [SizeW-1:0] t_size, input logic [HandleW-1:0] t_handle);
		logic [SeqW-1:0]  offs;
		logic [SlotW-1:0] slot;
		ack_t             r;
		bit               have;
		int               n;
		have = 1'b0;
		n = 0;
		if (t_op) begin
			if (next_seq != '0) begin
				r = '{next_seq - 1, 1'b0, '0, '0, 1'b1, 1'b0};
				awaited_acks.insert(awaited_acks.size(), r);
			end
			return;
		end
		if (!t_data || transfer_over)
			return;
		offs = t_seq - next_seq;
		if (offs >= SeqW'(WindowDefault))
			return;
		slot = head_slot + offs[SlotW-1:0];
		slot_busy[slot] = 1'b1;
		slot_size[slot] = t_size;
		slot_handle[slot] = t_handle;
		// drain in-order slots from the head, stop on a short payload or at MaxResults
		while (n < MaxResults && slot_busy[head_slot]) begin
			if (have)
				awaited_acks.insert(awaited_acks.size(), r);
			r = '{next_seq, 1'b1, slot_size[head_slot], slot_handle[head_slot], 1'b0,
				slot_size[head_slot] < full_size};
			have = 1'b1;
			n++;
			slot_busy[head_slot] = 1'b0;
			next_seq = next_seq + 1;
			head_slot = head_slot + SlotW'(1);
			if (r.done) begin
				transfer_over = 1'b1;
				break;
			end
		end
		if (have) begin
			r.last = 1'b1;
			awaited_acks.insert(awaited_acks.size(), r);
		end
	endtask

	task automatic check_field(input string name, input logic [SeqW-1:0] want,
			input logic [SeqW-1:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
			failed = 1'b1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		pkt_desc_t p;
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left <= 0;
		end else begin
			if (in_valid && !in_stall)
				take_item(op, is_data, seq_number, payload_size, payload_handle);
			// hold a stalled item
			if (!in_valid || !in_stall) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (packet_queue.size() != 0) begin
					p = packet_queue[0];
					packet_queue.delete(0);
					op <= p.op;
					is_data <= p.is_data;
					seq_number <= p.seq;
					payload_size <= p.size;
					payload_handle <= p.handle;
					in_valid <= 1'b1;
					if (!calm && $urandom_range(0, 4) == 0)
						gap_left <= $urandom_range(1, 12);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		ack_t e;
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (awaited_acks.size() == 0) begin
					$display("%0t: unexpected ack %0h expected none actual %0h", $time,
						ack_number, ack_number);
					failed = 1'b1;
				end else begin
					e = awaited_acks[0];
					awaited_acks.delete(0);
					check_field("ack_number", e.ack, ack_number);
					check_field("is_delivery", e.delivery, is_delivery);
					check_field("out_payload_size", e.size, out_payload_size);
					check_field("out_payload_handle", e.handle, out_payload_handle);
					check_field("last_of_run", e.last, last_of_run);
					check_field("transfer_done", e.done, transfer_done);
				end
			end
			if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				out_stall <= 1'b1;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				stall_left <= $urandom_range(0, 11);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task automatic push_packet(input logic t_op, input logic t_data, input logic [SeqW-1:0] t_seq,
			input logic [SizeW-1:0] t_size, input logic [HandleW-1:0] t_handle);
		pkt_desc_t p;
		p = '{t_op, t_data, t_seq, t_size, t_handle};
		packet_queue.insert(packet_queue.size(), p);
		if (t_op || t_data)
			stim_count++;
	endtask

	task automatic push_noise();
		case ($urandom_range(0, 3))
			0: push_packet(1'b1, 1'($urandom), $urandom, 11'($urandom), 16'($urandom));
			1: push_packet(1'b0, 1'b0, gen_next + $urandom_range(0, 31), 11'($urandom),
				16'($urandom));
			2: push_packet(1'b0, 1'b1, $urandom, 11'($urandom), 16'($urandom));
			default: push_packet(1'b0, 1'b1, gen_next - 1 - $urandom_range(0, 40),
				11'($urandom), 16'($urandom));
		endcase
	endtask

	// send sequence numbers gen_next .. gen_next+k-1 in shuffled or reversed order
	task automatic queue_burst(input int k, input int size_lo, input int size_hi,
			input int short_at);
		logic [SeqW-1:0]  order [WindowDefault];
		logic [SeqW-1:0]  tmp;
		logic [SizeW-1:0] sz;
		int               j;
		bit               reversed;
		reversed = ($urandom_range(0, 5) == 0);
		for (int i = 0; i < k; i++)
			order[i] = reversed ? gen_next + k - 1 - i : gen_next + i;
		if (!reversed) begin
			for (int i = k - 1; i > 0; i--) begin
				j = $urandom_range(0, i);
				tmp = order[i];
				order[i] = order[j];
				order[j] = tmp;
			end
		end
		for (int i = 0; i < k; i++) begin
			if ($urandom_range(0, 6) == 0)
				push_noise();
			if (short_at >= 0 && order[i] == gen_next + short_at)
				sz = SizeW'($urandom_range(0, int'(full_size) - 1));
			else
				sz = SizeW'($urandom_range(size_lo, size_hi));
			push_packet(1'b0, 1'b1, order[i], sz, 16'($urandom));
			if (short_at < 0 && $urandom_range(0, 7) == 0)
				push_packet(1'b0, 1'b1, order[$urandom_range(0, i)],
					SizeW'($urandom_range(size_lo, size_hi)), 16'($urandom));
		end
		gen_next = gen_next + k;
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (packet_queue.size() != 0 || in_valid || awaited_acks.size() != 0);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_full_size(input logic [SizeW-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		full_size = value;
	endtask

	function automatic int burst_len();
		return ($urandom_range(0, 9) == 0) ? WindowDefault : $urandom_range(1, 10);
	endfunction

	initial begin
		for (int i = 0; i < WindowDefault; i++) begin
			slot_busy[i] = 1'b0;
			slot_size[i] = '0;
			slot_handle[i] = '0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed: tick at zero, ignored type, window edges, duplicate, drains
		push_packet(1'b1, 1'b1, 32'h0, 11'd0, 16'h0);
		push_packet(1'b0, 1'b0, 32'h0, 11'd2047, 16'hffff);
		push_packet(1'b0, 1'b1, 32'd1, 11'd2047, 16'hffff);
		push_packet(1'b0, 1'b1, 32'd32, 11'd1500, 16'h1111);
		push_packet(1'b0, 1'b1, 32'd31, 11'd1464, 16'h0000);
		push_packet(1'b0, 1'b1, 32'hffff_ffff, 11'd1600, 16'h2222);
		push_packet(1'b0, 1'b1, 32'd1, 11'd1500, 16'h1234);
		push_packet(1'b0, 1'b1, 32'd0, 11'd1464, 16'h0000);
		push_packet(1'b1, 1'b1, 32'h0, 11'd0, 16'h0);
		push_packet(1'b1, 1'b0, 32'hffff_ffff, 11'd2047, 16'hffff);
		push_packet(1'b0, 1'b1, 32'd0, 11'd1800, 16'h3333);
		push_packet(1'b0, 1'b1, 32'd3, 11'd2047, 16'haaaa);
		push_packet(1'b0, 1'b1, 32'd2, 11'd1464, 16'h5555);
		push_packet(1'b0, 1'b1, 32'd35, 11'd1700, 16'h4444);
		push_packet(1'b0, 1'b1, 32'd36, 11'd1700, 16'h6666);
		push_packet(1'b0, 1'b1, 32'd4, 11'd2047, 16'h7777);
		push_packet(1'b1, 1'b0, 32'h0, 11'd0, 16'h0);
		gen_next = 32'd5;
		wait_idle();

		// zero full size: nothing is short, sizes span the whole field
		write_full_size(11'd0);
		stim_count = 0;
		while (stim_count < 150)
			queue_burst(burst_len(), 0, 2047, -1);
		wait_idle();

		write_full_size(11'd1);
		while (stim_count < 260)
			queue_burst(burst_len(), 1, 2047, -1);
		wait_idle();

		// last stretch without idling, then end the transfer
		write_full_size(11'd2047);
		calm = 1'b1;
		while (stim_count < 330)
			queue_burst(burst_len(), 2047, 2047, -1);
		queue_burst(12, 2047, 2047, $urandom_range(0, 11));
		for (int i = 0; i < 12; i++) begin
			if (i % 3 == 0)
				push_packet(1'b1, 1'($urandom), $urandom, 11'($urandom), 16'($urandom));
			else
				push_packet(1'b0, 1'b1, gen_next - 12 + $urandom_range(0, 31),
					11'($urandom), 16'($urandom));
		end
		wait_idle();

		if (failed)
			$display("status: fail");
		else
			$display("status: pass");
		$finish;
	end

endmodule
